### hdl/stnm_pkg.sv
// stnm_pkg: shared types, codes and constants of the scan temporal noise mask.
// Used by every module of the block; depends on nothing.
package stnm_pkg;

   localparam int DEFAULT_MAX_BEAMS  = 1024;
   localparam int DEFAULT_RANGE_BITS = 16;
   localparam int THR_W              = 16;
   localparam int VEL_W              = 16;
   localparam int SLOT_W             = 3;
   localparam int FRAME_SLOTS        = 4;
   localparam int QUEUE_DEPTH        = 4;

   localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(80);
   localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(5);

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_MOTION = 1'b1;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              filter_on;
      logic              ovf;
      logic              last;
      logic              sweep;
   } stnm_flags_type;

   typedef struct packed {
      logic clear_busy;
   } stnm_front_status_type;

   typedef struct packed {
      logic sweep_busy;
      logic sweep_done;
   } stnm_back_status_type;

   localparam int FLAGS_W        = $bits(stnm_flags_type);
   localparam int DEFAULT_ITEM_W = FLAGS_W + $clog2(DEFAULT_MAX_BEAMS) + DEFAULT_RANGE_BITS;

endpackage

### hdl/stnm_queue.sv
// stnm_queue: short first-in first-out queue between front and back.
// Depends on stnm_pkg for its default sizes.
module stnm_queue #(
   parameter int DATA_W = stnm_pkg::DEFAULT_ITEM_W,
   parameter int DEPTH  = stnm_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] wr_data,
   output logic              full,
   input  logic              pop,
   output logic              rd_valid,
   output logic [DATA_W-1:0] rd_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = count_ff == FULL_CNT;
   assign rd_valid = count_ff != '0;
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hdl/stnm_front.sv
// stnm_front: accepts transactions, tracks scan position, frame slot and filter enable.
// Depends on stnm_pkg; feeds stnm_queue and watches the mark clear sweep of stnm_back.
module stnm_front #(
   parameter int MAX_BEAMS  = stnm_pkg::DEFAULT_MAX_BEAMS,
   parameter int RANGE_BITS = stnm_pkg::DEFAULT_RANGE_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_type,
   input  logic [RANGE_BITS-1:0]                   req_range_mm,
   input  logic                                    req_last_beam,
   input  logic signed [stnm_pkg::VEL_W-1:0]       req_lin_x,
   input  logic signed [stnm_pkg::VEL_W-1:0]       req_lin_y,
   input  logic signed [stnm_pkg::VEL_W-1:0]       req_ang_z,
   input  logic                                    q_full,
   output logic                                    q_push,
   output stnm_pkg::stnm_flags_type                q_flags,
   output logic [$clog2(MAX_BEAMS)-1:0]            q_pos,
   output logic [RANGE_BITS-1:0]                   q_range,
   input  stnm_pkg::stnm_back_status_type          back_status,
   output stnm_pkg::stnm_front_status_type         front_status
);
   import stnm_pkg::*;

   localparam int POS_W = $clog2(MAX_BEAMS);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_BEAMS - 1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              ovf_ff, ovf_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              filter_ff, filter_in;
   logic              enreq_ff, enreq_in;
   logic              dirty_ff, dirty_in;
   logic              busy_ff, busy_in;
   logic              scan_start, filt_now, sweep_req, accept, motion_zero;

   assign scan_start  = (pos_ff == '0) && !ovf_ff;
   assign req_ready   = !q_full && !(busy_ff && enreq_ff && scan_start);
   assign accept      = req_valid && req_ready;
   assign q_push      = accept && (req_type == REQ_SAMPLE);
   assign filt_now    = scan_start ? enreq_ff : filter_ff;
   assign sweep_req   = scan_start && !enreq_ff && dirty_ff;
   assign motion_zero = (req_lin_x == '0) && (req_lin_y == '0) && (req_ang_z == '0);

   assign q_flags.slot      = slot_ff;
   assign q_flags.filter_on = filt_now;
   assign q_flags.ovf       = ovf_ff;
   assign q_flags.last      = req_last_beam;
   assign q_flags.sweep     = sweep_req;
   assign q_pos             = pos_ff;
   assign q_range           = req_range_mm;

   assign front_status.clear_busy = busy_ff;

   always_comb begin
      pos_in    = pos_ff;
      ovf_in    = ovf_ff;
      slot_in   = slot_ff;
      filter_in = filter_ff;
      enreq_in  = enreq_ff;
      dirty_in  = dirty_ff;
      busy_in   = busy_ff && !back_status.sweep_done;
      if (accept && (req_type == REQ_MOTION)) begin
         enreq_in = motion_zero;
      end
      if (q_push) begin
         filter_in = filt_now;
         if (sweep_req) begin
            dirty_in = 1'b0;
            busy_in  = 1'b1;
         end else if (filt_now) begin
            dirty_in = 1'b1;
         end
         if (req_last_beam) begin
            pos_in  = '0;
            ovf_in  = 1'b0;
            slot_in = (slot_ff == SLOT_LAST) ? SLOT_FIRST : slot_ff + SLOT_W'(1);
         end else if (!ovf_ff) begin
            if (pos_ff == LAST_POS) begin
               ovf_in = 1'b1;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         ovf_ff    <= 1'b0;
         slot_ff   <= SLOT_FIRST;
         filter_ff <= 1'b0;
         enreq_ff  <= 1'b0;
         dirty_ff  <= 1'b0;
         busy_ff   <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         ovf_ff    <= ovf_in;
         slot_ff   <= slot_in;
         filter_ff <= filter_in;
         enreq_ff  <= enreq_in;
         dirty_ff  <= dirty_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

### hdl/stnm_back.sv
// stnm_back: frame banks, noise mark memory, frame compare and result register.
// Depends on stnm_pkg; takes queued transactions from stnm_queue.
module stnm_back #(
   parameter int MAX_BEAMS  = stnm_pkg::DEFAULT_MAX_BEAMS,
   parameter int RANGE_BITS = stnm_pkg::DEFAULT_RANGE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_valid,
   output logic                               q_pop,
   input  stnm_pkg::stnm_flags_type           q_flags,
   input  logic [$clog2(MAX_BEAMS)-1:0]       q_pos,
   input  logic [RANGE_BITS-1:0]              q_range,
   input  logic [stnm_pkg::THR_W-1:0]         threshold,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [RANGE_BITS-1:0]              rsp_out_range_mm,
   output logic                               rsp_out_last,
   output logic                               rsp_beam_flagged,
   output stnm_pkg::stnm_back_status_type     back_status
);
   import stnm_pkg::*;

   localparam int POS_W = $clog2(MAX_BEAMS);
   localparam int CMP_W = (RANGE_BITS > THR_W) ? RANGE_BITS : THR_W;
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_BEAMS - 1);

   logic                  b_valid_ff, b_valid_in;
   stnm_flags_type        b_flags_ff;
   logic [POS_W-1:0]      b_pos_ff;
   logic [RANGE_BITS-1:0] b_range_ff;
   logic                  byp_ff, byp_data_ff;
   logic                  mark_mem_ff [MAX_BEAMS];
   logic                  mark_rd_ff;
   logic [RANGE_BITS-1:0] frame_rd [FRAME_SLOTS];
   logic                  sweep_busy_ff, sweep_busy_in;
   logic [POS_W-1:0]      sweep_cnt_ff, sweep_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RANGE_BITS-1:0] rsp_range_ff;
   logic                  rsp_last_ff, rsp_flag_ff;
   logic                  advance, pop, active, far, old_mark, new_mark, sweep_done;
   logic                  item_we, mark_we, mark_wd;
   logic [POS_W-1:0]      mark_wa;

   function automatic logic too_far(input logic [RANGE_BITS-1:0] a,
                                    input logic [RANGE_BITS-1:0] b,
                                    input logic [THR_W-1:0] thr);
      logic [CMP_W-1:0] d;
      d = CMP_W'((a >= b) ? a - b : b - a);
      return d > CMP_W'(thr);
   endfunction

   assign advance = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop     = q_valid && (!b_valid_ff || advance);
   assign q_pop   = pop;

   // one bank per stored frame slot
   for (genvar b = 0; b < FRAME_SLOTS; b++) begin : g_bank
      logic [RANGE_BITS-1:0] bank_mem_ff [MAX_BEAMS];
      logic [RANGE_BITS-1:0] bank_rd_ff;
      logic                  bank_we;

      assign bank_we     = pop && !q_flags.ovf && (q_flags.slot == SLOT_W'(b + 1));
      assign frame_rd[b] = bank_rd_ff;

      always_ff @(posedge clock) begin
         if (bank_we) begin
            bank_mem_ff[q_pos] <= q_range;
         end
         if (pop) begin
            bank_rd_ff <= bank_mem_ff[q_pos];
         end
      end
   end

   assign far = too_far(frame_rd[0], frame_rd[1], threshold)
             || too_far(frame_rd[0], frame_rd[2], threshold)
             || too_far(frame_rd[0], frame_rd[3], threshold)
             || too_far(frame_rd[0], b_range_ff, threshold)
             || too_far(frame_rd[1], frame_rd[3], threshold);

   assign active   = b_flags_ff.filter_on && !b_flags_ff.ovf;
   assign old_mark = byp_ff ? byp_data_ff : mark_rd_ff;
   assign new_mark = active && (old_mark || ((b_flags_ff.slot == SLOT_LAST) && far));

   // mark writes from the compare win over the clear sweep
   assign item_we = advance && active && (b_flags_ff.slot == SLOT_LAST);
   assign mark_we = item_we || sweep_busy_ff;
   assign mark_wa = item_we ? b_pos_ff : sweep_cnt_ff;
   assign mark_wd = item_we && new_mark;

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem_ff[mark_wa] <= mark_wd;
      end
      if (pop) begin
         mark_rd_ff <= mark_mem_ff[q_pos];
      end
   end

   assign sweep_done = sweep_busy_ff && (sweep_cnt_ff == LAST_POS);

   always_comb begin
      sweep_busy_in = sweep_busy_ff && !sweep_done;
      sweep_cnt_in  = sweep_busy_ff ? sweep_cnt_ff + POS_W'(1) : sweep_cnt_ff;
      if (pop && q_flags.sweep) begin
         sweep_busy_in = 1'b1;
         sweep_cnt_in  = '0;
      end
   end

   assign b_valid_in   = pop || (b_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sweep_busy_ff <= 1'b1;
         sweep_cnt_ff  <= '0;
      end else begin
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         sweep_busy_ff <= sweep_busy_in;
         sweep_cnt_ff  <= sweep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_flags_ff  <= q_flags;
         b_pos_ff    <= q_pos;
         b_range_ff  <= q_range;
         byp_ff      <= mark_we && (mark_wa == q_pos);
         byp_data_ff <= mark_wd;
      end
      if (advance) begin
         rsp_range_ff <= (active && new_mark) ? '0 : b_range_ff;
         rsp_last_ff  <= b_flags_ff.last;
         rsp_flag_ff  <= new_mark;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_range_mm = rsp_range_ff;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_beam_flagged = rsp_flag_ff;

   assign back_status.sweep_busy = sweep_busy_ff;
   assign back_status.sweep_done = sweep_done;

endmodule

### hdl/scan_temporal_noise_mask_top.sv
// scan_temporal_noise_mask_top: top level of the scan temporal noise mask.
// Depends on stnm_pkg, stnm_front, stnm_queue and stnm_back.
//
// Range samples and motion updates enter on the req_ channel; every range sample gives one
// transaction on the rsp_ channel, a motion update gives none. The block takes one
// transaction per cycle while the queue has room and no scan start waits on a sweep. A range
// sample passes through the queue, then the registered read of the four frame banks and the
// mark memory, and then the compare, ending in the result register. Each frame bank has one
// read and one write port, so every beam is a single read-compare-write. The noise marks are
// cleared by a sweep over every entry after reset, and again when a scan starts unfiltered
// after filtered scans; during a sweep, a scan start that would turn the filter on waits.
module scan_temporal_noise_mask_top #(
   parameter int MAX_BEAMS  = stnm_pkg::DEFAULT_MAX_BEAMS,
   parameter int RANGE_BITS = stnm_pkg::DEFAULT_RANGE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [RANGE_BITS-1:0]             req_range_mm,
   input  logic                              req_last_beam,
   input  logic signed [stnm_pkg::VEL_W-1:0] req_lin_x,
   input  logic signed [stnm_pkg::VEL_W-1:0] req_lin_y,
   input  logic signed [stnm_pkg::VEL_W-1:0] req_ang_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [RANGE_BITS-1:0]             rsp_out_range_mm,
   output logic                              rsp_out_last,
   output logic                              rsp_beam_flagged,
   input  logic                              csr_wr_en,
   input  logic [stnm_pkg::THR_W-1:0]        csr_wr_data
);
   import stnm_pkg::*;

   localparam int POS_W  = $clog2(MAX_BEAMS);
   localparam int ITEM_W = FLAGS_W + POS_W + RANGE_BITS;

   logic [THR_W-1:0]      thr_ff;
   logic                  q_push, q_full, q_valid, q_pop;
   stnm_flags_type        f_flags, b_flags;
   logic [POS_W-1:0]      f_pos, b_pos;
   logic [RANGE_BITS-1:0] f_range, b_range;
   logic [ITEM_W-1:0]     q_wr_data, q_rd_data;
   stnm_front_status_type front_status;
   stnm_back_status_type  back_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   stnm_front #(
      .MAX_BEAMS  (MAX_BEAMS),
      .RANGE_BITS (RANGE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_range_mm  (req_range_mm),
      .req_last_beam (req_last_beam),
      .req_lin_x     (req_lin_x),
      .req_lin_y     (req_lin_y),
      .req_ang_z     (req_ang_z),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_flags       (f_flags),
      .q_pos         (f_pos),
      .q_range       (f_range),
      .back_status   (back_status),
      .front_status  (front_status)
   );

   assign q_wr_data = {f_flags, f_pos, f_range};
   assign {b_flags, b_pos, b_range} = q_rd_data;

   stnm_queue #(
      .DATA_W (ITEM_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_data  (q_wr_data),
      .full     (q_full),
      .pop      (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rd_data)
   );

   stnm_back #(
      .MAX_BEAMS  (MAX_BEAMS),
      .RANGE_BITS (RANGE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_flags          (b_flags),
      .q_pos            (b_pos),
      .q_range          (b_range),
      .threshold        (thr_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_range_mm (rsp_out_range_mm),
      .rsp_out_last     (rsp_out_last),
      .rsp_beam_flagged (rsp_beam_flagged),
      .back_status      (back_status)
   );

   a_sweep_tracked: assert property (@(posedge clock) disable iff (reset)
      back_status.sweep_busy |-> front_status.clear_busy)
      else $error("mark clear sweep running while front sees no clear pending");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("transaction pushed into a full queue");

   a_masked_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beam_flagged) |-> (rsp_out_range_mm == '0))
      else $error("flagged beam delivered with nonzero range");

   a_done_ends_sweep: assert property (@(posedge clock) disable iff (reset)
      back_status.sweep_done |=> !front_status.clear_busy || $past(q_push))
      else $error("clear still pending after sweep finished");

endmodule

### verif/stnm_checker.sv
// stnm_checker: watches the req_, rsp_ and csr_ ports of the scan temporal noise mask,
// predicts every range sample's result and compares it with what the block returns.
// Depends on stnm_pkg.
module stnm_checker #(
   parameter int MAX_BEAMS  = stnm_pkg::DEFAULT_MAX_BEAMS,
   parameter int RANGE_BITS = stnm_pkg::DEFAULT_RANGE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_type,
   input  logic [RANGE_BITS-1:0]         req_range_mm,
   input  logic                          req_last_beam,
   input  logic [stnm_pkg::VEL_W-1:0]    req_lin_x,
   input  logic [stnm_pkg::VEL_W-1:0]    req_lin_y,
   input  logic [stnm_pkg::VEL_W-1:0]    req_ang_z,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [RANGE_BITS-1:0]         rsp_out_range_mm,
   input  logic                          rsp_out_last,
   input  logic                          rsp_beam_flagged,
   input  logic                          csr_wr_en,
   input  logic [stnm_pkg::THR_W-1:0]    csr_wr_data,
   output int                            error_count,
   output int                            results_pending
);
   import stnm_pkg::*;

   typedef struct {
      logic [RANGE_BITS-1:0] range_mm;
      logic                  last;
      logic                  flagged;
   } beam_result_type;

   logic [RANGE_BITS-1:0] frame_bank [FRAME_SLOTS][MAX_BEAMS];
   bit                    noise_marks [MAX_BEAMS];
   logic [SLOT_W-1:0]     scan_slot;
   int unsigned           beam_idx;
   bit                    beam_past_end;
   bit                    filter_active;
   bit                    filter_wanted;
   logic [THR_W-1:0]      threshold_mm;
   beam_result_type       expected_beams [$];
   beam_result_type       got_beam;
   beam_result_type       want_beam;
   int                    miscompares;

   function automatic string show_beam(input beam_result_type b);
      return $sformatf("range %0d last %0b flagged %0b", b.range_mm, b.last, b.flagged);
   endfunction

   function automatic void note_miscompare(input string what);
      miscompares++;
      if (miscompares <= 10)
         $display("[%0t] miscompare: %s", $realtime, what);
   endfunction

   function automatic bit beyond_threshold(input logic [RANGE_BITS-1:0] a,
                                           input logic [RANGE_BITS-1:0] b);
      logic [RANGE_BITS-1:0] gap;
      gap = (a > b) ? a - b : b - a;
      return gap > threshold_mm;
   endfunction

   task automatic mask_beam(input logic [RANGE_BITS-1:0] range_mm, input logic last);
      beam_result_type       res;
      logic [RANGE_BITS-1:0] f1;
      logic [RANGE_BITS-1:0] f2;
      logic [RANGE_BITS-1:0] f3;
      logic [RANGE_BITS-1:0] f4;
      res.range_mm = range_mm;
      res.last     = last;
      res.flagged  = 1'b0;
      // filter enable is latched at scan start
      if (beam_idx == 0 && !beam_past_end) begin
         filter_active = filter_wanted;
         if (!filter_active)
            foreach (noise_marks[i]) noise_marks[i] = 1'b0;
      end
      if (!beam_past_end) begin
         if (scan_slot != SLOT_LAST) begin
            frame_bank[scan_slot - 1'b1][beam_idx] = range_mm;
         end else if (filter_active) begin
            f1 = frame_bank[0][beam_idx];
            f2 = frame_bank[1][beam_idx];
            f3 = frame_bank[2][beam_idx];
            f4 = frame_bank[3][beam_idx];
            if (beyond_threshold(f1, f2) || beyond_threshold(f1, f3) ||
                beyond_threshold(f1, f4) || beyond_threshold(f1, range_mm) ||
                beyond_threshold(f2, f4))
               noise_marks[beam_idx] = 1'b1;
         end
         res.flagged = noise_marks[beam_idx];
         if (filter_active && res.flagged)
            res.range_mm = '0;
      end
      if (last) begin
         beam_idx      = 0;
         beam_past_end = 1'b0;
         scan_slot     = (scan_slot == SLOT_LAST) ? SLOT_FIRST : scan_slot + 1'b1;
      end else if (!beam_past_end) begin
         if (beam_idx + 1 >= MAX_BEAMS)
            beam_past_end = 1'b1;
         else
            beam_idx++;
      end
      expected_beams.push_back(res);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (frame_bank[s, p]) frame_bank[s][p] = '0;
         foreach (noise_marks[i]) noise_marks[i] = 1'b0;
         scan_slot     = SLOT_FIRST;
         beam_idx      = 0;
         beam_past_end = 1'b0;
         filter_active = 1'b0;
         filter_wanted = 1'b0;
         threshold_mm  = THR_RESET;
         expected_beams.delete();
      end else begin
         if (csr_wr_en)
            threshold_mm = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            got_beam.range_mm = rsp_out_range_mm;
            got_beam.last     = rsp_out_last;
            got_beam.flagged  = rsp_beam_flagged;
            if (expected_beams.size() == 0) begin
               note_miscompare({"unexpected transaction, ", show_beam(got_beam)});
            end else begin
               want_beam = expected_beams.pop_front();
               if (got_beam.range_mm !== want_beam.range_mm ||
                   got_beam.last !== want_beam.last ||
                   got_beam.flagged !== want_beam.flagged)
                  note_miscompare({"expected ", show_beam(want_beam),
                                   ", got ", show_beam(got_beam)});
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == REQ_MOTION)
               filter_wanted = req_lin_x == '0 && req_lin_y == '0 && req_ang_z == '0;
            else
               mask_beam(req_range_mm, req_last_beam);
         end
      end
      error_count     <= miscompares;
      results_pending <= expected_beams.size();
   end

endmodule

### verif/tb_scan_temporal_noise_mask_top.sv
// tb_scan_temporal_noise_mask_top: stimulus and verdict for scan_temporal_noise_mask_top.
// Drives a filtered fill rotation, directed corner scans and random scans over several
// thresholds; depends on stnm_pkg, the block and stnm_checker.
module tb_scan_temporal_noise_mask_top;
   import stnm_pkg::*;

   localparam int MAX_BEAMS  = DEFAULT_MAX_BEAMS;
   localparam int RANGE_BITS = DEFAULT_RANGE_BITS;
   localparam int RANGE_MAX  = 2 ** RANGE_BITS - 1;
   localparam int FILL_BEAMS = 16;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_type;
   logic [RANGE_BITS-1:0] req_range_mm;
   logic                  req_last_beam;
   logic [VEL_W-1:0]      req_lin_x;
   logic [VEL_W-1:0]      req_lin_y;
   logic [VEL_W-1:0]      req_ang_z;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [RANGE_BITS-1:0] rsp_out_range_mm;
   logic                  rsp_out_last;
   logic                  rsp_beam_flagged;
   logic                  csr_wr_en;
   logic [THR_W-1:0]      csr_wr_data;
   int                    error_count;
   int                    results_pending;

   bit                    sender_gaps     = 1'b1;
   bit                    receiver_stalls = 1'b1;
   int                    samples_sent;
   int                    motions_sent;
   int                    threshold_writes;
   int unsigned           beam_base [MAX_BEAMS];

   always #4 clock = ~clock;

   scan_temporal_noise_mask_top #(
      .MAX_BEAMS  (MAX_BEAMS),
      .RANGE_BITS (RANGE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_range_mm     (req_range_mm),
      .req_last_beam    (req_last_beam),
      .req_lin_x        (req_lin_x),
      .req_lin_y        (req_lin_y),
      .req_ang_z        (req_ang_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_range_mm (rsp_out_range_mm),
      .rsp_out_last     (rsp_out_last),
      .rsp_beam_flagged (rsp_beam_flagged),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   stnm_checker #(
      .MAX_BEAMS  (MAX_BEAMS),
      .RANGE_BITS (RANGE_BITS)
   ) beam_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_range_mm     (req_range_mm),
      .req_last_beam    (req_last_beam),
      .req_lin_x        (req_lin_x),
      .req_lin_y        (req_lin_y),
      .req_ang_z        (req_ang_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_range_mm (rsp_out_range_mm),
      .rsp_out_last     (rsp_out_last),
      .rsp_beam_flagged (rsp_beam_flagged),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (error_count),
      .results_pending  (results_pending)
   );

   task automatic send_transaction(input logic typ, input logic [RANGE_BITS-1:0] rng,
                                   input logic lst, input logic [VEL_W-1:0] lx,
                                   input logic [VEL_W-1:0] ly, input logic [VEL_W-1:0] az);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= typ;
      req_range_mm  <= rng;
      req_last_beam <= lst;
      req_lin_x     <= lx;
      req_lin_y     <= ly;
      req_ang_z     <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typ == REQ_MOTION)
         motions_sent++;
      else
         samples_sent++;
   endtask

   // velocities are don't-care on range samples, so they carry noise
   task automatic send_beam(input int unsigned rng, input logic lst);
      send_transaction(REQ_SAMPLE, RANGE_BITS'(rng), lst, VEL_W'($urandom),
                       VEL_W'($urandom), VEL_W'($urandom));
   endtask

   task automatic send_motion(input logic [VEL_W-1:0] lx, input logic [VEL_W-1:0] ly,
                              input logic [VEL_W-1:0] az);
      send_transaction(REQ_MOTION, RANGE_BITS'($urandom), 1'($urandom), lx, ly, az);
   endtask

   task automatic send_random_motion();
      int unsigned pick;
      logic [VEL_W-1:0] v;
      pick = $urandom_range(0, 5);
      v    = VEL_W'($urandom);
      case (pick)
         0, 1, 2: send_motion('0, '0, '0);
         3: send_motion(v, '0, '0);
         4: send_motion('0, v, '0);
         default: send_motion(VEL_W'($urandom), VEL_W'($urandom), v);
      endcase
   endtask

   task automatic send_scan(input int unsigned beams, input int jitter);
      int r;
      for (int unsigned p = 0; p < beams; p++) begin
         if ($urandom_range(0, 39) == 0)
            send_random_motion();
         r = int'(beam_base[p % MAX_BEAMS]) + int'($urandom_range(0, 2 * jitter)) - jitter;
         case ($urandom_range(0, 39))
            0: r = 0;
            1: r = RANGE_MAX;
            2: r = int'($urandom_range(0, RANGE_MAX));
            default: ;
         endcase
         if (r < 0)
            r = 0;
         if (r > RANGE_MAX)
            r = RANGE_MAX;
         send_beam(r, p == beams - 1);
      end
   endtask

   task automatic wait_drained(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // the block may still be sweeping its marks, so allow a full sweep first
   task automatic set_threshold(input logic [THR_W-1:0] value);
      wait_drained(MAX_BEAMS + 16);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      threshold_writes++;
   endtask

   initial begin
      rsp_ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [THR_W-1:0] phase_threshold [4];
      int unsigned      scan_len;
      int               jitter_pick [4];
      int               phase_start;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= REQ_SAMPLE;
      req_range_mm  <= '0;
      req_last_beam <= 1'b0;
      req_lin_x     <= '0;
      req_lin_y     <= '0;
      req_ang_z     <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      foreach (beam_base[i]) beam_base[i] = $urandom_range(600, RANGE_MAX - 600);
      jitter_pick        = '{0, 40, 120, 600};
      phase_threshold[0] = '0;
      phase_threshold[1] = '1;
      phase_threshold[2] = THR_W'($urandom_range(20, 300));
      phase_threshold[3] = THR_W'($urandom);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // one filtered rotation fills every frame entry that later scans reach
      send_motion('0, '0, '0);
      repeat (5) send_scan(FILL_BEAMS, 120);

      // directed corner scans at the default threshold
      send_motion(16'h8000, '0, '0);
      send_motion('0, 16'h7fff, '0);
      send_motion('0, '0, 16'h0001);
      send_beam(1000, 1'b0);
      send_beam(1000, 1'b1);
      send_motion('0, '0, '0);
      send_beam(1080, 1'b0);
      send_motion('0, '0, '0);
      send_beam(1000, 1'b1);
      send_beam(1000, 1'b0);
      send_beam(1000, 1'b1);
      send_beam(1080, 1'b0);
      send_beam(1000, 1'b1);
      // difference equal to the threshold on beam 0, one above it on beam 1
      send_beam(1000, 1'b0);
      send_beam(1081, 1'b1);
      // marks persist into the next filtered scan
      send_beam(0, 1'b0);
      send_beam(RANGE_MAX, 1'b1);
      // unfiltered rotation, including a slot 5 scan with no compare
      send_motion(16'h7fff, 16'h8000, '0);
      for (int s = 0; s < 4; s++) begin
         send_beam((s % 2) ? RANGE_MAX : 0, 1'b0);
         send_beam(1000, 1'b1);
      end

      for (int ph = 0; ph < 4; ph++) begin
         set_threshold(phase_threshold[ph]);
         if (ph == 3) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end
         scan_len    = $urandom_range(1, 12);
         phase_start = samples_sent;
         while (samples_sent - phase_start < 95) begin
            if ($urandom_range(0, 4) == 0)
               scan_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, FILL_BEAMS)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0)
               send_random_motion();
            send_scan(scan_len, jitter_pick[$urandom_range(0, 3)]);
         end
      end

      wait_drained(32);
      $display("covered %0d range samples and %0d motion updates, %0d threshold writes,",
               samples_sent, motions_sent, threshold_writes);
      $display("filtered and unfiltered rotations of up to %0d beams, %0d miscompares",
               FILL_BEAMS, error_count);
      if (error_count == 0 && results_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #16000000;
      $display("Verification failed");
      $finish;
   end

endmodule
